// ===== rtl/mp3fs_pkg.sv =====
// ----------------------------------------------------------------------------
// MP3 frame sync package
// Shared constants, lookup tables and controller/datapath link types.
// ----------------------------------------------------------------------------
`default_nettype none

package mp3fs_pkg;

  localparam int unsigned MaxBufferBytes = 65536;
  localparam int unsigned OffsetCapInt   =
    (MaxBufferBytes - 1 > 65535) ? 65535 : MaxBufferBytes - 1;
  localparam logic [15:0] OffsetCap      = 16'(OffsetCapInt);

  localparam logic [31:0] SyncMask   = 32'hffe00000;
  localparam int unsigned FrameConst = 144000;

  localparam int unsigned ProdW     = 26;
  localparam int unsigned QuoW      = 11;
  localparam int unsigned DivSteps  = QuoW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  typedef enum logic [1:0] {
    ST_FOUND     = 2'd0,
    ST_FREE      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    VER_MPEG1  = 2'd0,
    VER_MPEG2  = 2'd1,
    VER_MPEG25 = 2'd2
  } version_e;

  typedef struct packed {
    logic accept;
    logic mul;
    logic div_step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic miss;
  } sts_t;

  function automatic logic [15:0] rate_base(input logic [1:0] sr);
    logic [15:0] r;
    case (sr)
      2'd0:    r = 16'd44100;
      2'd1:    r = 16'd48000;
      2'd2:    r = 16'd32000;
      default: r = 16'd44100;
    endcase
    return r;
  endfunction

  function automatic logic [8:0] kbps_lookup(input logic lsf, input logic [3:0] br);
    logic [8:0] k;
    if (!lsf) begin
      case (br)
        4'd1:    k = 9'd32;
        4'd2:    k = 9'd40;
        4'd3:    k = 9'd48;
        4'd4:    k = 9'd56;
        4'd5:    k = 9'd64;
        4'd6:    k = 9'd80;
        4'd7:    k = 9'd96;
        4'd8:    k = 9'd112;
        4'd9:    k = 9'd128;
        4'd10:   k = 9'd160;
        4'd11:   k = 9'd192;
        4'd12:   k = 9'd224;
        4'd13:   k = 9'd256;
        4'd14:   k = 9'd320;
        default: k = 9'd0;
      endcase
    end else begin
      case (br)
        4'd1:    k = 9'd8;
        4'd2:    k = 9'd16;
        4'd3:    k = 9'd24;
        4'd4:    k = 9'd32;
        4'd5:    k = 9'd40;
        4'd6:    k = 9'd48;
        4'd7:    k = 9'd56;
        4'd8:    k = 9'd64;
        4'd9:    k = 9'd80;
        4'd10:   k = 9'd96;
        4'd11:   k = 9'd112;
        4'd12:   k = 9'd128;
        4'd13:   k = 9'd144;
        4'd14:   k = 9'd160;
        default: k = 9'd0;
      endcase
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mp3fs_in_if.sv =====
// ----------------------------------------------------------------------------
// MP3 frame sync input channel
// Byte stream with buffer start and end markers, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mp3fs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;

  modport source (output valid, data_byte, first_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/mp3fs_out_if.sv =====
// ----------------------------------------------------------------------------
// MP3 frame sync result channel
// Decoded header fields or not-found status, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mp3fs_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] header_offset;
  logic [1:0]  mpeg_version;
  logic [1:0]  channel_count;
  logic [15:0] sample_rate_hz;
  logic [8:0]  bit_rate_kbps;
  logic [10:0] frame_bytes;
  logic [5:0]  side_info_bytes;
  logic [10:0] samples_per_frame;

  modport source (output valid, status, header_offset, mpeg_version, channel_count,
                  sample_rate_hz, bit_rate_kbps, frame_bytes, side_info_bytes,
                  samples_per_frame, input ready);
  modport sink   (input valid, status, header_offset, mpeg_version, channel_count,
                  sample_rate_hz, bit_rate_kbps, frame_bytes, side_info_bytes,
                  samples_per_frame, output ready);
endinterface

`default_nettype wire

// ===== rtl/mp3fs_ctrl.sv =====
// ----------------------------------------------------------------------------
// MP3 frame sync controller
// Sequences scan, frame size multiply, iterative divide and result load.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3fs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  input  wire mp3fs_pkg::sts_t   sts_i,
  output mp3fs_pkg::cmd_t        cmd_o
);

  typedef enum logic [3:0] {
    S_SCAN = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_LOAD = 4'b1000
  } ctrl_state_e;

  ctrl_state_e                        state_q, state_d;
  logic [mp3fs_pkg::DivCntW-1:0]      cnt_q, cnt_d;
  logic                               out_valid_q, out_valid_d;
  logic                               accept;

  assign in_ready_o  = (state_q == S_SCAN);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    cmd_o        = '0;
    cmd_o.accept = accept;
    out_valid_d  = out_valid_q & ~out_ready_i;
    case (state_q)
      S_SCAN: begin
        if (accept && sts_i.hit) begin
          state_d = S_MUL;
        end else if (accept && sts_i.miss) begin
          state_d = S_LOAD;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        cnt_d     = mp3fs_pkg::DivCntW'(mp3fs_pkg::DivSteps - 1);
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == '0) begin
          state_d = S_LOAD;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      S_LOAD: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_SCAN;
        end
      end
      default: state_d = S_SCAN;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SCAN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mp3fs_dp.sv =====
// ----------------------------------------------------------------------------
// MP3 frame sync datapath
// Byte window, offset counter, header decode, frame size divider, result regs.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3fs_dp (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mp3fs_pkg::cmd_t   cmd_i,
  output mp3fs_pkg::sts_t        sts_o,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              first_byte_i,
  input  wire logic              last_byte_i,
  output logic [1:0]             status_o,
  output logic [15:0]            header_offset_o,
  output logic [1:0]             mpeg_version_o,
  output logic [1:0]             channel_count_o,
  output logic [15:0]            sample_rate_hz_o,
  output logic [8:0]             bit_rate_kbps_o,
  output logic [10:0]            frame_bytes_o,
  output logic [5:0]             side_info_bytes_o,
  output logic [10:0]            samples_per_frame_o
);

  localparam int unsigned PW = mp3fs_pkg::ProdW;
  localparam int unsigned QW = mp3fs_pkg::QuoW;

  logic [23:0]   window_q, window_d, window_eff;
  logic [15:0]   seen_q, seen_d, seen_eff;
  logic [1:0]    fill_q, fill_d, fill_eff;
  logic          done_q, done_d, done_eff;
  logic [31:0]   hdr_word;
  logic          hdr_ok;
  logic          hit, miss;

  logic [31:0]   hdr_q;
  logic [15:0]   offset_q;
  logic          nf_q;
  logic [PW-1:0] rem_q;
  logic [PW-1:0] dsh_q;
  logic [QW-1:0] quo_q;

  logic [1:0]    ver;
  logic          lsf, m25;
  logic [15:0]   rate;
  logic [15:0]   divisor;
  logic [8:0]    kbps;
  logic [1:0]    ch;
  logic [5:0]    side;
  logic [10:0]   spf;
  logic          rem_ge;

  logic [1:0]    status_q;
  logic [15:0]   header_offset_q;
  logic [1:0]    mpeg_version_q;
  logic [1:0]    channel_count_q;
  logic [15:0]   sample_rate_hz_q;
  logic [8:0]    bit_rate_kbps_q;
  logic [10:0]   frame_bytes_q;
  logic [5:0]    side_info_bytes_q;
  logic [10:0]   samples_per_frame_q;

  // clear on buffer start before using the byte
  assign window_eff = first_byte_i ? '0 : window_q;
  assign seen_eff   = first_byte_i ? '0 : seen_q;
  assign fill_eff   = first_byte_i ? '0 : fill_q;
  assign done_eff   = first_byte_i ? 1'b0 : done_q;

  assign hdr_word = {window_eff, data_byte_i};
  assign hdr_ok   = ((hdr_word & mp3fs_pkg::SyncMask) == mp3fs_pkg::SyncMask) &&
                    (hdr_word[18:17] == 2'b01) &&
                    (hdr_word[15:12] != 4'hf) &&
                    (hdr_word[11:10] != 2'b11);
  assign hit  = !done_eff && (fill_eff == 2'd3) && hdr_ok;
  assign miss = !done_eff && !hit && last_byte_i;

  assign sts_o.hit  = hit;
  assign sts_o.miss = miss;

  always_comb begin
    window_d = window_eff;
    seen_d   = seen_eff;
    fill_d   = fill_eff;
    done_d   = done_eff;
    if (!done_eff) begin
      if (hit) begin
        done_d = 1'b1;
      end else begin
        if (fill_eff == 2'd3) begin
          if (seen_eff < mp3fs_pkg::OffsetCap) begin
            seen_d = seen_eff + 1'b1;
          end
        end else begin
          fill_d = fill_eff + 1'b1;
        end
        window_d = hdr_word[23:0];
        done_d   = last_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      seen_q   <= '0;
      fill_q   <= '0;
      done_q   <= 1'b0;
    end else if (cmd_i.accept) begin
      window_q <= window_d;
      seen_q   <= seen_d;
      fill_q   <= fill_d;
      done_q   <= done_d;
    end
  end

  // header decode
  always_comb begin
    case (hdr_q[20:19])
      2'b00:   ver = mp3fs_pkg::VER_MPEG25;
      2'b10:   ver = mp3fs_pkg::VER_MPEG2;
      default: ver = mp3fs_pkg::VER_MPEG1;
    endcase
    lsf     = (ver != mp3fs_pkg::VER_MPEG1);
    m25     = (ver == mp3fs_pkg::VER_MPEG25);
    rate    = mp3fs_pkg::rate_base(hdr_q[11:10]) >> ({1'b0, lsf} + {1'b0, m25});
    divisor = rate << lsf;
    kbps    = mp3fs_pkg::kbps_lookup(lsf, hdr_q[15:12]);
    ch      = (hdr_q[7:6] == 2'b11) ? 2'd1 : 2'd2;
    if (ch == 2'd2 && !lsf) begin
      side = 6'd32;
    end else if (ch == 2'd1 && lsf) begin
      side = 6'd9;
    end else begin
      side = 6'd17;
    end
    spf = lsf ? 11'd576 : 11'd1152;
  end

  assign rem_ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (hit || miss)) begin
      hdr_q    <= hdr_word;
      offset_q <= seen_eff;
      nf_q     <= !hit;
    end
    if (cmd_i.mul) begin
      rem_q <= PW'(kbps * mp3fs_pkg::FrameConst);
      dsh_q <= {divisor, (PW - 16)'(0)};
    end else if (cmd_i.div_step) begin
      if (rem_ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QW-2:0], rem_ge};
    end
    if (cmd_i.load) begin
      if (nf_q) begin
        status_q            <= mp3fs_pkg::ST_NOT_FOUND;
        header_offset_q     <= '0;
        mpeg_version_q      <= '0;
        channel_count_q     <= '0;
        sample_rate_hz_q    <= '0;
        bit_rate_kbps_q     <= '0;
        frame_bytes_q       <= '0;
        side_info_bytes_q   <= '0;
        samples_per_frame_q <= '0;
      end else begin
        status_q            <= (hdr_q[15:12] == 4'd0) ? mp3fs_pkg::ST_FREE
                                                       : mp3fs_pkg::ST_FOUND;
        header_offset_q     <= offset_q;
        mpeg_version_q      <= ver;
        channel_count_q     <= ch;
        sample_rate_hz_q    <= rate;
        bit_rate_kbps_q     <= kbps;
        frame_bytes_q       <= (kbps == '0) ? '0 : (quo_q + {10'd0, hdr_q[9]});
        side_info_bytes_q   <= side;
        samples_per_frame_q <= spf;
      end
    end
  end

  assign status_o            = status_q;
  assign header_offset_o     = header_offset_q;
  assign mpeg_version_o      = mpeg_version_q;
  assign channel_count_o     = channel_count_q;
  assign sample_rate_hz_o    = sample_rate_hz_q;
  assign bit_rate_kbps_o     = bit_rate_kbps_q;
  assign frame_bytes_o       = frame_bytes_q;
  assign side_info_bytes_o   = side_info_bytes_q;
  assign samples_per_frame_o = samples_per_frame_q;

endmodule

`default_nettype wire

// ===== rtl/mp3_frame_sync_header_decoder.sv =====
// ----------------------------------------------------------------------------
// MP3 frame sync header decoder
// Scans a byte buffer for the first MPEG Layer III frame header and decodes it.
//
// in_i carries one buffer byte per transaction with first_byte and last_byte
// markers. out_o carries one result per buffer: the decoded header of the
// first match, or a not-found status when the last byte passes unmatched.
// While scanning, the block takes one byte per cycle. A matching byte starts
// the frame size computation: a multiply step, then a restoring divider
// that yields one quotient bit per cycle, then a load step; the block takes
// no byte until the load step is done. A last byte without a match goes
// straight to the load step. The result sits in an output register until
// taken; when the receiver stalls, scanning goes on and a further result
// waits in the load step until the register frees. Bytes after a result are
// dropped until first_byte starts a new buffer. Reset clears the window, the
// offset counter, the done flag and the output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3_frame_sync_header_decoder (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  mp3fs_in_if.sink    in_i,
  mp3fs_out_if.source out_o
);

  mp3fs_pkg::cmd_t cmd;
  mp3fs_pkg::sts_t sts;

  mp3fs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mp3fs_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .data_byte_i         (in_i.data_byte),
    .first_byte_i        (in_i.first_byte),
    .last_byte_i         (in_i.last_byte),
    .status_o            (out_o.status),
    .header_offset_o     (out_o.header_offset),
    .mpeg_version_o      (out_o.mpeg_version),
    .channel_count_o     (out_o.channel_count),
    .sample_rate_hz_o    (out_o.sample_rate_hz),
    .bit_rate_kbps_o     (out_o.bit_rate_kbps),
    .frame_bytes_o       (out_o.frame_bytes),
    .side_info_bytes_o   (out_o.side_info_bytes),
    .samples_per_frame_o (out_o.samples_per_frame)
  );

endmodule

`default_nettype wire

// ===== bench/mp3_frame_sync_header_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// MP3 frame sync header decoder testbench
// Feeds byte buffers into the decoder: a stimulus table of hand-picked
// headers and near misses, then random buffers. Most random buffers carry a
// well-formed header with random fields inside noise. The rest carry broken
// headers or noise only. Each accepted byte runs through a local header
// scanner that predicts the report, and every result transaction is compared
// field by field with the oldest queued report. Both handshakes idle and stall
// at random.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3_frame_sync_header_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mp3fs_pkg::*;

  typedef struct packed {
    status_e     status;
    logic [15:0] offset;
    version_e    version;
    logic [1:0]  channels;
    logic [15:0] rate;
    logic [8:0]  kbps;
    logic [10:0] frame;
    logic [5:0]  side;
    logic [10:0] spf;
  } hdr_result_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        first;
    logic        last;
    logic        known;
    hdr_result_t res;
  } script_row_t;

  localparam int unsigned Mpeg1Kbps [15] =
    '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320};
  localparam int unsigned LsfKbps [15] =
    '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160};
  localparam int unsigned RateBase [3] = '{44100, 48000, 32000};

  localparam hdr_result_t NoReport = '0;
  localparam hdr_result_t NotFound =
    '{ST_NOT_FOUND, 16'd0, VER_MPEG1, 2'd0, 16'd0, 9'd0, 11'd0, 6'd0, 11'd0};
  localparam hdr_result_t Mpeg1Top =
    '{ST_FOUND, 16'd0, VER_MPEG1, 2'd1, 16'd32000, 9'd320, 11'd1441, 6'd17, 11'd1152};
  localparam hdr_result_t Mpeg2Free =
    '{ST_FREE, 16'd1, VER_MPEG2, 2'd2, 16'd24000, 9'd0, 11'd0, 6'd17, 11'd576};
  localparam hdr_result_t Mpeg25Top =
    '{ST_FOUND, 16'd0, VER_MPEG25, 2'd1, 16'd8000, 9'd160, 11'd1440, 6'd9, 11'd576};

  localparam script_row_t Script [26] = '{
    '{8'hFF, 1'b1, 1'b1, 1'b1, NotFound},
    '{8'hFF, 1'b1, 1'b0, 1'b0, NoReport},
    '{8'hFB, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'hEA, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'hC4, 1'b0, 1'b0, 1'b1, Mpeg1Top},
    '{8'h55, 1'b0, 1'b1, 1'b0, NoReport},
    '{8'hFF, 1'b1, 1'b0, 1'b0, NoReport},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'hF3, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'h04, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'h00, 1'b0, 1'b0, 1'b1, Mpeg2Free},
    '{8'hFF, 1'b1, 1'b0, 1'b0, NoReport},
    '{8'hE3, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'hE8, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'hC0, 1'b0, 1'b1, 1'b1, Mpeg25Top},
    '{8'hFF, 1'b1, 1'b0, 1'b0, NoReport},
    '{8'hEB, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'h50, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'h80, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'hFF, 1'b1, 1'b0, 1'b0, NoReport},
    '{8'hFB, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'hF0, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'hFF, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'hFB, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'h9C, 1'b0, 1'b0, 1'b0, NoReport},
    '{8'h00, 1'b0, 1'b1, 1'b1, NotFound}
  };

  localparam int unsigned RandomBytes     = 360;
  localparam int unsigned DrainCycles     = 40;
  localparam int unsigned TimeoutNs       = 4_000_000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  mp3fs_in_if  in_if ();
  mp3fs_out_if out_if ();

  mp3_frame_sync_header_decoder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  logic [23:0]  scan_window = '0;
  logic [15:0]  scan_offset = '0;
  logic [1:0]   scan_fill   = '0;
  logic         scan_done   = 1'b0;
  hdr_result_t  pending_reports [$];
  int unsigned  live_bytes  = 0;
  int unsigned  errors      = 0;
  logic         calm        = 1'b0;

  always #2 clk_i = ~clk_i;

  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll >= 95) return $urandom_range(10, 40);
    if (roll >= 65) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic logic [7:0] noise_byte();
    return ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
  endfunction

  function automatic logic predict_report(input logic [7:0] b, input logic f,
                                          input logic l, output hdr_result_t r);
    logic [31:0] h;
    int unsigned rate;
    int unsigned kbps;
    int unsigned shift;
    logic        lsf;
    r = NoReport;
    if (f) begin
      scan_window = '0;
      scan_offset = '0;
      scan_fill   = '0;
      scan_done   = 1'b0;
    end
    if (scan_done) return 1'b0;
    h = {scan_window, b};
    if (scan_fill == 2'd3 && (h & SyncMask) == SyncMask && h[18:17] == 2'b01 &&
        h[15:12] != 4'hF && h[11:10] != 2'b11) begin
      r.version  = (h[20:19] == 2'b00) ? VER_MPEG25 : (h[19] ? VER_MPEG1 : VER_MPEG2);
      lsf        = (r.version != VER_MPEG1);
      shift      = int'(lsf) + ((r.version == VER_MPEG25) ? 1 : 0);
      rate       = RateBase[h[11:10]] >> shift;
      kbps       = lsf ? LsfKbps[h[15:12]] : Mpeg1Kbps[h[15:12]];
      r.status   = (h[15:12] == 4'd0) ? ST_FREE : ST_FOUND;
      r.offset   = scan_offset;
      r.channels = (h[7:6] == 2'b11) ? 2'd1 : 2'd2;
      r.rate     = 16'(rate);
      r.kbps     = 9'(kbps);
      r.frame    = (kbps == 0) ? 11'd0 : 11'(kbps * FrameConst / (rate << lsf) + h[9]);
      if (r.channels == 2'd2 && !lsf) r.side = 6'd32;
      else if (r.channels == 2'd1 && lsf) r.side = 6'd9;
      else r.side = 6'd17;
      r.spf      = lsf ? 11'd576 : 11'd1152;
      scan_done  = 1'b1;
      return 1'b1;
    end
    if (scan_fill == 2'd3) begin
      if (scan_offset < OffsetCap) scan_offset++;
    end else begin
      scan_fill++;
    end
    scan_window = h[23:0];
    if (l) begin
      r         = NotFound;
      scan_done = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic push_byte(input logic [7:0] b, input logic f, input logic l,
                           input logic known = 1'b0, input hdr_result_t fixed = '0);
    int unsigned gap;
    hdr_result_t r;
    logic        hit;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.data_byte  <= b;
    in_if.first_byte <= f;
    in_if.last_byte  <= l;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    if (f || !scan_done) live_bytes++;
    hit = predict_report(b, f, l, r);
    if (known) pending_reports.push_back(fixed);
    else if (hit) pending_reports.push_back(r);
  endtask

  task automatic send_buffer();
    logic [7:0]  bytes [$];
    logic [31:0] h;
    int unsigned kind;
    int unsigned pick;
    logic        closed;
    kind   = $urandom_range(0, 99);
    closed = ($urandom_range(0, 9) != 0);
    repeat ($urandom_range(kind < 85 ? 0 : 1, kind < 85 ? 6 : 8)) begin
      bytes.push_back(noise_byte());
    end
    if (kind < 85) begin
      h = {11'h7FF, 2'($urandom), 2'b01, 1'($urandom), 4'($urandom_range(0, 14)),
           2'($urandom_range(0, 2)), 10'($urandom)};
      if (kind >= 70) begin
        pick = $urandom_range(0, 2);
        case (pick)
          0: begin
            h[15:12] = 4'hF;
          end
          1: begin
            h[11:10] = 2'b11;
          end
          default: begin
            pick     = $urandom_range(0, 2);
            h[18:17] = (pick == 1) ? 2'b11 : 2'(pick);
          end
        endcase
      end
      for (int i = 3; i >= 0; i--) bytes.push_back(h[8*i +: 8]);
      repeat ($urandom_range(0, 4)) bytes.push_back(noise_byte());
    end
    foreach (bytes[i]) begin
      push_byte(bytes[i], i == 0, closed && i == bytes.size() - 1);
    end
  endtask

  initial begin : drain
    int unsigned hold;
    hold = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!rst_ni || hold > 0) begin
        out_if.ready <= 1'b0;
        if (hold > 0) hold--;
      end else if (calm) begin
        out_if.ready <= 1'b1;
      end else begin
        hold = idle_len();
        out_if.ready <= (hold == 0);
        if (hold > 0) hold--;
      end
    end
  end

  always @(posedge clk_i) begin
    hdr_result_t want;
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction with no report pending");
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("status", want.status, out_if.status);
        check_field("header_offset", want.offset, out_if.header_offset);
        check_field("mpeg_version", want.version, out_if.mpeg_version);
        check_field("channel_count", want.channels, out_if.channel_count);
        check_field("sample_rate_hz", want.rate, out_if.sample_rate_hz);
        check_field("bit_rate_kbps", want.kbps, out_if.bit_rate_kbps);
        check_field("frame_bytes", want.frame, out_if.frame_bytes);
        check_field("side_info_bytes", want.side, out_if.side_info_bytes);
        check_field("samples_per_frame", want.spf, out_if.samples_per_frame);
      end
    end
  end

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  initial begin
    in_if.valid      <= 1'b0;
    in_if.data_byte  <= 8'h00;
    in_if.first_byte <= 1'b0;
    in_if.last_byte  <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Script[i]) begin
      push_byte(Script[i].data, Script[i].first, Script[i].last, Script[i].known,
                Script[i].res);
    end

    live_bytes = 0;
    while (live_bytes < RandomBytes) begin
      if ($urandom_range(0, 9) == 0) calm = !calm;
      send_buffer();
    end
    calm = 1'b0;
    in_if.valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire
